>>> src/double_ended_queue_core_assert.svh
// Assertion macros shared by the queue checker
`ifndef DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_CORE_ASSERT_SVH

// Condition holds at every edge outside reset
`define DQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the cycle after the antecedent, outside reset
`define DQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Same, checked during reset as well
`define DQ_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/dq_pkg.sv
// Types and codes shared by the double-ended queue modules
package dq_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_READ_AT    = 3'd2;
  localparam logic [2:0] OP_READ_FRONT = 3'd3;
  localparam logic [2:0] OP_READ_BACK  = 3'd4;
  localparam logic [2:0] OP_CLEAR      = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] push_value;
    logic [7:0]         position;
  } dq_req_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [8:0]         fill_count;
    logic               is_empty;
  } dq_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;   // request accepted: access ring, update pointers
    logic load;   // move pending result into output register
  } dq_cmd_t;

endpackage

>>> src/dq_ctrl.sv
// Request sequencer and output handshake for the double-ended queue
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dq_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_ACCESS = 2'b10
  } dq_state_t;

  dq_state_t state_r, state_nxt;
  logic      out_valid_r, out_valid_nxt;

  always_comb begin
    cmd.exec = (state_r == S_IDLE) && in_valid;
    cmd.load = (state_r == S_ACCESS) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_ACCESS;
      end
      S_ACCESS: begin
        if (cmd.load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> src/dq_datapath.sv
// Ring store, start pointer, word count and result registers
module dq_datapath
  import dq_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  dq_cmd_t cmd,
  input  dq_req_t req,
  output dq_rsp_t rsp
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = ((PW > 8) ? PW : 8) + 1;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic [PW-1:0]         start_r, start_nxt;
  logic [CW-1:0]         count_r, count_nxt;
  logic [DATA_WIDTH-1:0] rdata_r;
  logic [1:0]            st_r, st_nxt;
  logic [8:0]            fill_r;
  logic                  empty_r;
  logic                  rd_ok_r, rd_ok_nxt;
  dq_rsp_t               rsp_r;

  logic                  full, empty;
  logic [SW-1:0]         count_sw, offset, sum, wrapped;
  logic [PW-1:0]         slot, front_slot, wr_addr;
  logic                  wr_en;
  logic [DATA_WIDTH-1:0] wr_data;

  assign full     = (count_r == CW'(CAPACITY));
  assign empty    = (count_r == '0);
  assign count_sw = SW'(count_r);

  always_comb begin
    case (req.operation)
      OP_PUSH_BACK: offset = count_sw;
      OP_READ_AT:   offset = SW'(req.position);
      OP_READ_BACK: offset = count_sw - SW'(1);
      default:      offset = '0;
    endcase
  end

  // offset stays below CAPACITY whenever the slot is used, so one subtract wraps it
  assign sum        = SW'(start_r) + offset;
  assign wrapped    = (sum >= SW'(CAPACITY)) ? (sum - SW'(CAPACITY)) : sum;
  assign slot       = wrapped[PW-1:0];
  assign front_slot = (start_r == '0) ? PW'(CAPACITY - 1) : (start_r - PW'(1));
  assign wr_data    = DATA_WIDTH'($unsigned(req.push_value));

  always_comb begin
    start_nxt = start_r;
    count_nxt = count_r;
    st_nxt    = ST_OK;
    rd_ok_nxt = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = slot;
    case (req.operation)
      OP_PUSH_FRONT: begin
        wr_addr = front_slot;
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          start_nxt = front_slot;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_READ_AT: begin
        if (SW'(req.position) >= count_sw) st_nxt = ST_RANGE;
        else rd_ok_nxt = 1'b1;
      end
      OP_READ_FRONT, OP_READ_BACK: begin
        if (empty) st_nxt = ST_RANGE;
        else rd_ok_nxt = 1'b1;
      end
      OP_CLEAR: begin
        start_nxt = '0;
        count_nxt = '0;
      end
      default: ;
    endcase
  end

  // at most one write or one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) mem[wr_addr] <= wr_data;
    if (cmd.exec && rd_ok_nxt) rdata_r <= mem[slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      start_r <= start_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_r    <= st_nxt;
      rd_ok_r <= rd_ok_nxt;
      fill_r  <= 9'(count_nxt);
      empty_r <= (count_nxt == '0);
    end
    if (cmd.load) begin
      rsp_r.read_value <= rd_ok_r ? 32'(rdata_r) : '0;
      rsp_r.status     <= st_r;
      rsp_r.fill_count <= fill_r;
      rsp_r.is_empty   <= empty_r;
    end
  end

  assign rsp = rsp_r;

endmodule

>>> src/double_ended_queue_core.sv
// Top level of the bounded double-ended queue
//
//  channel  | ports                        | carries
//  ---------+------------------------------+---------------------------------
//  request  | in_valid / in_ready / in_data   | operation, push word, position
//  result   | out_valid / out_ready / out_data | read word, status, size, empty
//
// The accept edge does the single ring access (write or registered read)
// and pointer update; S_ACCESS then loads the output register once it is free
// or out_ready is high. Only then is in_ready raised for the next request.
// Reset (rst_n low, synchronous) empties the queue; stored words are kept.
// A result held by out_ready low lets one more request be accepted, then
// in_ready stays low until the output register frees.
module double_ended_queue_core
  import dq_pkg::*;
#(
  parameter int CAPACITY   = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dq_req_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output dq_rsp_t out_data
);

  dq_cmd_t cmd;

  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  dq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .req   (in_data),
    .rsp   (out_data)
  );

endmodule

>>> src/dq_checker.sv
// Port-level checks for the double-ended queue, bound to the top level
`include "double_ended_queue_core_assert.svh"

module dq_port_checker
  import dq_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_valid,
  input logic    in_ready,
  input logic    out_valid,
  input logic    out_ready,
  input dq_rsp_t out_data
);

  `DQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result word dropped or changed while stalled")
  `DQ_ASSERT_ALWAYS(a_empty_flag, !out_valid || (out_data.is_empty == (out_data.fill_count == 9'd0)), "empty flag disagrees with size")
  `DQ_ASSERT_ALWAYS(a_err_zero, !out_valid || out_data.status == ST_OK || out_data.read_value == '0, "error word carries read data")
  `DQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second word taken before the first finished")
  `DQ_ASSERT_NEXT_RST(a_rst_quiet, !rst_n, !out_valid, "result valid right after reset")

endmodule

bind double_ended_queue_core dq_port_checker u_dq_checker (.*);
